// ===== hw/rtl/wrs_pkg.sv =====
// shared constants and controller/datapath interface types for the wide run suppressor
package wrs_pkg;

    localparam int RUN_DEPTH = 64;
    localparam int RUN_IDX_W = $clog2(RUN_DEPTH);
    localparam int RUN_LEN_W = $clog2(RUN_DEPTH + 1);

    localparam int PIX_W     = 8;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;
    localparam int CMP_W     = (RUN_LEN_W > CFG_W) ? RUN_LEN_W : CFG_W;

    localparam logic [CFG_IDX_W-1:0] REG_FILTER_ENABLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RUN_WIDTH = 1'd1;

    localparam logic [CFG_W-1:0] MAX_RUN_WIDTH_RST = 7'd16;

    typedef struct packed {
        logic take;
        logic read;
        logic emit_replay;
        logic emit_final;
    } dp_cmd_t;

    typedef struct packed {
        logic plan_out;
        logic plan_replay;
        logic replay_last;
        logic out_free;
    } dp_sts_t;

endpackage

// ===== hw/rtl/wide_run_suppressor.sv =====
// top level of the wide run suppressor
//
// Pixel stream filter that zeroes runs of nonzero pixels reaching max_run_width along a row.
// A pixel that only extends a short run is accepted and gives no result. A pixel closing a
// run of held pixels is accepted, then each held pixel is read from the 64 x 8 run buffer
// (registered read) and output, then the final result, each waiting for a free output
// register; an unheld pixel goes straight to its final result. The output register lets the
// next input beat in while the last result still waits. Config writes are taken every cycle.
module wide_run_suppressor (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [wrs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wrs_pkg::CFG_W-1:0]       cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [wrs_pkg::PIX_W-1:0]       s_tdata,   // [7:0] pixel_in
    input  logic                            s_tlast,   // row_end
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [wrs_pkg::PIX_W-1:0]       m_tdata,   // [7:0] pixel_out
    output logic                            m_tuser,   // [0] burst_last
    output logic                            m_tlast    // row_end_out
);

    wrs_pkg::dp_cmd_t cmd;
    wrs_pkg::dp_sts_t sts;

    assign cfg_ready = 1'b1;
    assign s_tready  = cmd.take;

    wrs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .sts      (sts),
        .cmd      (cmd)
    );

    wrs_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (s_tvalid),
        .in_pix         (s_tdata),
        .in_last        (s_tlast),
        .out_ready      (m_tready),
        .out_valid      (m_tvalid),
        .out_pix        (m_tdata),
        .out_burst_last (m_tuser),
        .out_row_end    (m_tlast),
        .cmd            (cmd),
        .sts            (sts)
    );

endmodule

// ===== hw/rtl/wrs_ram.sv =====
// generic single write port, single read port ram with registered read
module wrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/wrs_ctrl.sv =====
// sequencer for the wide run suppressor: accept, replay of held pixels, final result
module wrs_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  wrs_pkg::dp_sts_t sts,
    output wrs_pkg::dp_cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_READ  = 4'b0010,
        ST_EMIT  = 4'b0100,
        ST_FINAL = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.take = 1'b1;
                if (in_valid && sts.plan_out)
                begin
                    state_next = sts.plan_replay ? ST_READ : ST_FINAL;
                end
            end
            ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_replay = 1'b1;
                    state_next      = sts.replay_last ? ST_FINAL : ST_READ;
                end
            end
            ST_FINAL:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_final = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/wrs_datapath.sv =====
// run tracking, run buffer, config registers and output register
module wrs_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    input  logic [wrs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wrs_pkg::CFG_W-1:0]       cfg_data,
    input  logic                            in_valid,
    input  logic [wrs_pkg::PIX_W-1:0]       in_pix,
    input  logic                            in_last,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic [wrs_pkg::PIX_W-1:0]       out_pix,
    output logic                            out_burst_last,
    output logic                            out_row_end,
    input  wrs_pkg::dp_cmd_t                cmd,
    output wrs_pkg::dp_sts_t                sts
);

    logic                            filter_enable_reg;
    logic [wrs_pkg::CFG_W-1:0]       max_run_width_reg;
    logic [wrs_pkg::RUN_LEN_W-1:0]   run_length_reg, run_length_next;

    logic [wrs_pkg::RUN_IDX_W-1:0]   cnt_reg, cnt_next;
    logic                            zero_reg, zero_next;
    logic [wrs_pkg::PIX_W-1:0]       final_pix_reg, final_pix_next;
    logic                            last_reg;
    logic [wrs_pkg::RUN_IDX_W-1:0]   idx_reg;

    logic                            out_valid_reg;
    logic [wrs_pkg::PIX_W-1:0]       out_pix_reg;
    logic                            out_burst_reg;
    logic                            out_row_end_reg;

    logic                            accept;
    logic                            plan_out;
    logic                            buf_wr;
    logic [wrs_pkg::PIX_W-1:0]       rd_data;
    logic [wrs_pkg::CMP_W-1:0]       mrw_ext, thr, rl_ext, grow_ext;
    logic                            rl_sat;
    logic [wrs_pkg::RUN_IDX_W-1:0]   rl_idx;

    assign accept = in_valid && cmd.take;
    assign rl_sat = run_length_reg >= wrs_pkg::RUN_LEN_W'(wrs_pkg::RUN_DEPTH);
    assign rl_idx = run_length_reg[wrs_pkg::RUN_IDX_W-1:0];

    // effective threshold, clamped to 1 .. buffer depth
    assign mrw_ext  = wrs_pkg::CMP_W'(max_run_width_reg);
    assign rl_ext   = wrs_pkg::CMP_W'(run_length_reg);
    assign grow_ext = rl_ext + wrs_pkg::CMP_W'(1);

    always_comb
    begin
        priority if (mrw_ext == '0)
        begin
            thr = wrs_pkg::CMP_W'(1);
        end
        else if (mrw_ext > wrs_pkg::CMP_W'(wrs_pkg::RUN_DEPTH))
        begin
            thr = wrs_pkg::CMP_W'(wrs_pkg::RUN_DEPTH);
        end
        else
        begin
            thr = mrw_ext;
        end
    end

    // plan for the input beat: held pixels to replay, then one final result, or no result
    always_comb
    begin
        plan_out        = 1'b1;
        buf_wr          = 1'b0;
        cnt_next        = rl_sat ? '0 : rl_idx;
        zero_next       = 1'b0;
        final_pix_next  = in_pix;
        run_length_next = '0;
        priority if (!filter_enable_reg)
        begin
            run_length_next = '0;
        end
        else if (in_pix != '0)
        begin
            if (rl_sat)
            begin
                final_pix_next  = '0;
                run_length_next = run_length_reg;
            end
            else
            begin
                buf_wr = 1'b1;
                if (grow_ext >= thr)
                begin
                    zero_next       = 1'b1;
                    final_pix_next  = '0;
                    run_length_next = wrs_pkg::RUN_LEN_W'(wrs_pkg::RUN_DEPTH);
                end
                else if (!in_last)
                begin
                    plan_out        = 1'b0;
                    run_length_next = grow_ext[wrs_pkg::RUN_LEN_W-1:0];
                end
            end
        end
        else
        begin
            // a run ended by background, zeroed if the threshold fell to or below its length
            zero_next       = rl_ext >= thr;
            final_pix_next  = '0;
            run_length_next = '0;
        end
        if (in_last)
        begin
            run_length_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_enable_reg <= 1'b1;
            max_run_width_reg <= wrs_pkg::MAX_RUN_WIDTH_RST;
            run_length_reg    <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == wrs_pkg::REG_FILTER_ENABLE)
                begin
                    filter_enable_reg <= cfg_data[0];
                end
                else if (cfg_index == wrs_pkg::REG_MAX_RUN_WIDTH)
                begin
                    max_run_width_reg <= cfg_data;
                end
            end
            if (accept)
            begin
                run_length_reg <= run_length_next;
            end
            if (cmd.emit_replay || cmd.emit_final)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cnt_reg       <= cnt_next;
            zero_reg      <= zero_next;
            final_pix_reg <= final_pix_next;
            last_reg      <= in_last;
            idx_reg       <= '0;
        end
        else if (cmd.emit_replay)
        begin
            idx_reg <= idx_reg + wrs_pkg::RUN_IDX_W'(1);
        end
        if (cmd.emit_replay)
        begin
            out_pix_reg     <= zero_reg ? '0 : rd_data;
            out_burst_reg   <= 1'b0;
            out_row_end_reg <= 1'b0;
        end
        else if (cmd.emit_final)
        begin
            out_pix_reg     <= final_pix_reg;
            out_burst_reg   <= 1'b1;
            out_row_end_reg <= last_reg;
        end
    end

    wrs_ram #(
        .WIDTH (wrs_pkg::PIX_W),
        .DEPTH (wrs_pkg::RUN_DEPTH)
    ) u_run_buf (
        .clk     (clk),
        .wr_en   (accept && buf_wr),
        .wr_addr (rl_idx),
        .wr_data (in_pix),
        .rd_en   (cmd.read),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    assign sts.plan_out    = plan_out;
    assign sts.plan_replay = cnt_next != '0;
    assign sts.replay_last = idx_reg == (cnt_reg - wrs_pkg::RUN_IDX_W'(1));
    assign sts.out_free    = !out_valid_reg || out_ready;

    assign out_valid      = out_valid_reg;
    assign out_pix        = out_pix_reg;
    assign out_burst_last = out_burst_reg;
    assign out_row_end    = out_row_end_reg;

    a_run_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        run_length_reg <= wrs_pkg::RUN_LEN_W'(wrs_pkg::RUN_DEPTH))
        else $error("run length beyond buffer depth");

    a_emit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_replay || cmd.emit_final) |-> sts.out_free)
        else $error("result loaded while output register is occupied");

    a_emit_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.emit_replay && cmd.emit_final))
        else $error("replay and final result loaded together");

    a_row_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_last) |=> run_length_reg == '0)
        else $error("run state not cleared after row end");

endmodule
